// File: design/ecb_pkg.sv
// ---------------------------------------------------------------------------
// ecb_pkg: shared types and constants of the Euler camera basis unit
// Fixed-point constants of the sine polynomial, pipeline depth, result type
// and saturation helpers.
// ---------------------------------------------------------------------------
package ecb_pkg;

  localparam int NUM_STAGES = 9;
  localparam int SIN_STAGES = 4;
  localparam int BAS_STAGES = 3;
  localparam int SE_STAGES  = 2;

  localparam logic [14:0] SIN_A   = 15'd25736;
  localparam logic [13:0] SIN_B   = 14'd10512;
  localparam logic [10:0] SIN_C   = 11'd1160;
  localparam logic [14:0] QUARTER = 15'd16384;

  typedef logic signed [15:0] vec_t;
  typedef logic signed [31:0] pos_t;

  typedef struct packed {
    pos_t        lookat_x;
    pos_t        lookat_y;
    pos_t        lookat_z;
    logic [23:0] view_distance;
  } ecb_carry_t;

  typedef struct packed {
    vec_t fwd_x;
    vec_t fwd_y;
    vec_t fwd_z;
    vec_t up_x;
    vec_t up_y;
    vec_t up_z;
    vec_t side_x;
    vec_t side_y;
    vec_t side_z;
    pos_t eye_x;
    pos_t eye_y;
    pos_t eye_z;
  } ecb_result_t;

  function automatic vec_t sat16(input logic signed [49:0] v);
    if (v > 50'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -50'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic pos_t sat32(input logic signed [41:0] v);
    if (v > 42'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -42'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: design/ecb_if.sv
// ---------------------------------------------------------------------------
// ecb_if: channel interfaces of the Euler camera basis unit
// Valid/ready channels for the angle item and the basis result.
// ---------------------------------------------------------------------------
interface ecb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;
  logic signed [31:0] lookat_x;
  logic signed [31:0] lookat_y;
  logic signed [31:0] lookat_z;
  logic [23:0]        view_distance;

  modport source(output valid, yaw_angle, pitch_angle, roll_angle, lookat_x, lookat_y,
                 lookat_z, view_distance, input ready);
  modport sink(input valid, yaw_angle, pitch_angle, roll_angle, lookat_x, lookat_y,
               lookat_z, view_distance, output ready);
endinterface

interface ecb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] fwd_x;
  logic signed [15:0] fwd_y;
  logic signed [15:0] fwd_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic signed [15:0] side_x;
  logic signed [15:0] side_y;
  logic signed [15:0] side_z;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;

  modport source(output valid, fwd_x, fwd_y, fwd_z, up_x, up_y, up_z, side_x, side_y,
                 side_z, eye_x, eye_y, eye_z, input ready);
  modport sink(input valid, fwd_x, fwd_y, fwd_z, up_x, up_y, up_z, side_x, side_y,
               side_z, eye_x, eye_y, eye_z, output ready);
endinterface

// File: design/ecb_sin.sv
// ---------------------------------------------------------------------------
// ecb_sin: four-stage sine lane
// Odd polynomial sine of a 16-bit binary angle, Q1.14 result.
// ---------------------------------------------------------------------------
module ecb_sin (
  input  logic                            clk,
  input  logic [ecb_pkg::SIN_STAGES-1:0]  en,
  input  logic [15:0]                     angle,
  output ecb_pkg::vec_t                   sin_val
);
  import ecb_pkg::*;

  logic [14:0] x_c;
  logic [29:0] xx_c;
  logic [25:0] p2_c;
  logic [28:0] p3_c;
  logic [29:0] p4_c;

  logic [14:0] x1_r, x2a_r, x2b_r;
  logic [14:0] sq1_r, sq2_r;
  logic [13:0] k2_r;
  logic [14:0] m3_r;
  logic        n1_r, n2_r, n3_r;
  vec_t        s4_r;
  logic [15:0] s_mag;

  // Fold the angle into the first quadrant.
  always_comb begin
    x_c  = angle[14] ? 15'(QUARTER - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    xx_c = x_c * x_c;
    p2_c = sq1_r * SIN_C;
    p3_c = sq2_r * k2_r;
    p4_c = x2b_r * m3_r;
    s_mag = p4_c[29:14];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_r  <= x_c;
      sq1_r <= xx_c[28:14];
      n1_r  <= angle[15];
    end
    if (en[1]) begin
      x2a_r <= x1_r;
      sq2_r <= sq1_r;
      k2_r  <= 14'(SIN_B - 14'(p2_c[25:14]));
      n2_r  <= n1_r;
    end
    if (en[2]) begin
      x2b_r <= x2a_r;
      m3_r  <= 15'(SIN_A - 15'(p3_c[28:14]));
      n3_r  <= n2_r;
    end
    if (en[3]) begin
      s4_r <= n3_r ? -$signed(s_mag) : $signed(s_mag);
    end
  end

  assign sin_val = s4_r;

endmodule

// File: design/ecb_basis.sv
// ---------------------------------------------------------------------------
// ecb_basis: forward and up vectors
// Three stages: exact products, second products and rounding, Q42 rounding.
// ---------------------------------------------------------------------------
module ecb_basis (
  input  logic                            clk,
  input  logic [ecb_pkg::BAS_STAGES-1:0]  en,
  input  ecb_pkg::vec_t                   s_y,
  input  ecb_pkg::vec_t                   c_y,
  input  ecb_pkg::vec_t                   s_p,
  input  ecb_pkg::vec_t                   c_p,
  input  ecb_pkg::vec_t                   s_r,
  input  ecb_pkg::vec_t                   c_r,
  output ecb_pkg::vec_t                   fwd_x,
  output ecb_pkg::vec_t                   fwd_y,
  output ecb_pkg::vec_t                   fwd_z,
  output ecb_pkg::vec_t                   up_x,
  output ecb_pkg::vec_t                   up_y,
  output ecb_pkg::vec_t                   up_z
);
  import ecb_pkg::*;

  logic signed [31:0] fx_e_r, fz_e_r, u1_e_r, ysp_e_r, ysr_e_r, cysr_e_r, spcr_e_r;
  vec_t               sp_e_r, cr_e_r, cy_e_r;

  logic signed [47:0] px_f_r, pz_f_r;
  logic signed [31:0] ysr_f_r, cysr_f_r;
  vec_t               fx_f_r, fy_f_r, fz_f_r, u1_f_r;

  vec_t               fx_g_r, fy_g_r, fz_g_r, ux_g_r, uy_g_r, uz_g_r;
  logic signed [49:0] ux_sum, uz_sum;
  logic signed [31:0] fx_rnd, fz_rnd, u1_rnd;

  always_comb begin
    fx_rnd = (fx_e_r + 32'sd8192) >>> 14;
    fz_rnd = (fz_e_r + 32'sd8192) >>> 14;
    u1_rnd = (u1_e_r + 32'sd8192) >>> 14;
    ux_sum = -(50'(cysr_f_r) <<< 14) - 50'(px_f_r) + (50'sd1 <<< 27);
    uz_sum = -(50'(ysr_f_r) <<< 14) - 50'(pz_f_r) + (50'sd1 <<< 27);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fx_e_r   <= s_y * c_p;
      fz_e_r   <= c_p * c_y;
      u1_e_r   <= c_p * c_r;
      ysp_e_r  <= s_y * s_p;
      ysr_e_r  <= s_y * s_r;
      cysr_e_r <= c_y * s_r;
      spcr_e_r <= s_p * c_r;
      sp_e_r   <= s_p;
      cr_e_r   <= c_r;
      cy_e_r   <= c_y;
    end
    if (en[1]) begin
      px_f_r   <= ysp_e_r * cr_e_r;
      pz_f_r   <= spcr_e_r * cy_e_r;
      ysr_f_r  <= ysr_e_r;
      cysr_f_r <= cysr_e_r;
      fx_f_r   <= fx_rnd[15:0];
      fy_f_r   <= sp_e_r;
      fz_f_r   <= fz_rnd[15:0];
      u1_f_r   <= sat16(50'(u1_rnd));
    end
    if (en[2]) begin
      fx_g_r <= fx_f_r;
      fy_g_r <= fy_f_r;
      fz_g_r <= fz_f_r;
      uy_g_r <= u1_f_r;
      ux_g_r <= sat16(ux_sum >>> 28);
      uz_g_r <= sat16(uz_sum >>> 28);
    end
  end

  assign fwd_x = fx_g_r;
  assign fwd_y = fy_g_r;
  assign fwd_z = fz_g_r;
  assign up_x  = ux_g_r;
  assign up_y  = uy_g_r;
  assign up_z  = uz_g_r;

endmodule

// File: design/ecb_side_eye.sv
// ---------------------------------------------------------------------------
// ecb_side_eye: side vector and eye position
// Products in the first stage, sums, rounding and saturation in the second.
// ---------------------------------------------------------------------------
module ecb_side_eye (
  input  logic                           clk,
  input  logic [ecb_pkg::SE_STAGES-1:0]  en,
  input  ecb_pkg::vec_t                  fwd_x,
  input  ecb_pkg::vec_t                  fwd_y,
  input  ecb_pkg::vec_t                  fwd_z,
  input  ecb_pkg::vec_t                  up_x,
  input  ecb_pkg::vec_t                  up_y,
  input  ecb_pkg::vec_t                  up_z,
  input  logic [23:0]                    view_distance,
  input  ecb_pkg::pos_t                  lookat_x,
  input  ecb_pkg::pos_t                  lookat_y,
  input  ecb_pkg::pos_t                  lookat_z,
  output ecb_pkg::ecb_result_t           result
);
  import ecb_pkg::*;

  logic signed [24:0] dist_s;
  logic signed [31:0] yz_r, zy_r, zx_r, xz_r, xy_r, yx_r;
  logic signed [40:0] ex_r, eyy_r, ez_r;
  vec_t               fx_h_r, fy_h_r, fz_h_r, ux_h_r, uy_h_r, uz_h_r;
  ecb_result_t        res_r;
  logic signed [34:0] sx_sum, sy_sum, sz_sum;
  logic signed [41:0] ox, oy, oz;

  assign dist_s = $signed({1'b0, view_distance});

  always_comb begin
    sx_sum = (35'(yz_r) - 35'(zy_r) + 35'sd8192) >>> 14;
    sy_sum = (35'(zx_r) - 35'(xz_r) + 35'sd8192) >>> 14;
    sz_sum = (35'(xy_r) - 35'(yx_r) + 35'sd8192) >>> 14;
    ox = (42'(ex_r) + 42'sd8192) >>> 14;
    oy = (42'(eyy_r) + 42'sd8192) >>> 14;
    oz = (42'(ez_r) + 42'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      yz_r   <= fwd_y * up_z;
      zy_r   <= fwd_z * up_y;
      zx_r   <= fwd_z * up_x;
      xz_r   <= fwd_x * up_z;
      xy_r   <= fwd_x * up_y;
      yx_r   <= fwd_y * up_x;
      ex_r   <= fwd_x * dist_s;
      eyy_r  <= fwd_y * dist_s;
      ez_r   <= fwd_z * dist_s;
      fx_h_r <= fwd_x;
      fy_h_r <= fwd_y;
      fz_h_r <= fwd_z;
      ux_h_r <= up_x;
      uy_h_r <= up_y;
      uz_h_r <= up_z;
    end
    if (en[1]) begin
      res_r.fwd_x  <= fx_h_r;
      res_r.fwd_y  <= fy_h_r;
      res_r.fwd_z  <= fz_h_r;
      res_r.up_x   <= ux_h_r;
      res_r.up_y   <= uy_h_r;
      res_r.up_z   <= uz_h_r;
      res_r.side_x <= sat16(50'(sx_sum));
      res_r.side_y <= sat16(50'(sy_sum));
      res_r.side_z <= sat16(50'(sz_sum));
      res_r.eye_x  <= sat32(42'(lookat_x) - ox);
      res_r.eye_y  <= sat32(42'(lookat_y) - oy);
      res_r.eye_z  <= sat32(42'(lookat_z) - oz);
    end
  end

  assign result = res_r;

endmodule

// File: design/euler_to_camera_basis_unit.sv
// ---------------------------------------------------------------------------
// euler_to_camera_basis_unit: Euler angles to camera basis vectors
// Yaw, pitch and roll become forward, up and side vectors (Q1.14) and the
// eye position (Q23.8) at a distance from the look-at point.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   in_ch     sink       three angles, look-at point, viewing distance
//   out_ch    source     forward, up, side vectors and eye position
//
// The unit is a nine-stage pipeline: four stages of sine lanes, three of
// basis products and two of side and eye arithmetic. It takes one transfer
// per cycle unless every stage is full and the output is stalled.
// Reset (rst_n, synchronous) clears only the stage valid bits.
// Each stage holds its item while the stage after it is full and stalled,
// so a stall on the output fills the empty stages before the input stops.
// ---------------------------------------------------------------------------
module euler_to_camera_basis_unit (
  input  logic      clk,
  input  logic      rst_n,
  ecb_in_if.sink    in_ch,
  ecb_out_if.source out_ch
);
  import ecb_pkg::*;

  // One valid bit per pipeline stage; the last stage is the output register.
  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  logic [NUM_STAGES-1:0] en;

  // Look-at point and distance travel beside the arithmetic.
  ecb_carry_t carry_r [NUM_STAGES-1];

  vec_t s_y, c_y, s_p, c_p, s_r, c_r;
  vec_t fx, fy, fz, ux, uy, uz;
  ecb_result_t result;

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ch.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_ch.valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      carry_r[0] <= '{lookat_x: in_ch.lookat_x, lookat_y: in_ch.lookat_y,
                      lookat_z: in_ch.lookat_z, view_distance: in_ch.view_distance};
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (en[k]) begin
        carry_r[k] <= carry_r[k-1];
      end
    end
  end

  // Six sine lanes; cosine is the sine a quarter turn ahead.
  ecb_sin u_sin_y (.clk, .en(en[SIN_STAGES-1:0]), .angle(in_ch.yaw_angle), .sin_val(s_y));
  ecb_sin u_cos_y (.clk, .en(en[SIN_STAGES-1:0]),
                   .angle(16'(in_ch.yaw_angle + 16'sd16384)), .sin_val(c_y));
  ecb_sin u_sin_p (.clk, .en(en[SIN_STAGES-1:0]), .angle(in_ch.pitch_angle), .sin_val(s_p));
  ecb_sin u_cos_p (.clk, .en(en[SIN_STAGES-1:0]),
                   .angle(16'(in_ch.pitch_angle + 16'sd16384)), .sin_val(c_p));
  ecb_sin u_sin_r (.clk, .en(en[SIN_STAGES-1:0]), .angle(in_ch.roll_angle), .sin_val(s_r));
  ecb_sin u_cos_r (.clk, .en(en[SIN_STAGES-1:0]),
                   .angle(16'(in_ch.roll_angle + 16'sd16384)), .sin_val(c_r));

  ecb_basis u_basis (
    .clk,
    .en(en[SIN_STAGES+BAS_STAGES-1:SIN_STAGES]),
    .s_y, .c_y, .s_p, .c_p, .s_r, .c_r,
    .fwd_x(fx), .fwd_y(fy), .fwd_z(fz),
    .up_x(ux), .up_y(uy), .up_z(uz)
  );

  // Distance is taken from the carry beside the basis output; look-at from
  // the next stage, beside the products.
  ecb_side_eye u_side_eye (
    .clk,
    .en(en[NUM_STAGES-1:SIN_STAGES+BAS_STAGES]),
    .fwd_x(fx), .fwd_y(fy), .fwd_z(fz),
    .up_x(ux), .up_y(uy), .up_z(uz),
    .view_distance(carry_r[NUM_STAGES-3].view_distance),
    .lookat_x(carry_r[NUM_STAGES-2].lookat_x),
    .lookat_y(carry_r[NUM_STAGES-2].lookat_y),
    .lookat_z(carry_r[NUM_STAGES-2].lookat_z),
    .result
  );

  assign in_ch.ready   = en[0];
  assign out_ch.valid  = vld_r[NUM_STAGES-1];
  assign out_ch.fwd_x  = result.fwd_x;
  assign out_ch.fwd_y  = result.fwd_y;
  assign out_ch.fwd_z  = result.fwd_z;
  assign out_ch.up_x   = result.up_x;
  assign out_ch.up_y   = result.up_y;
  assign out_ch.up_z   = result.up_z;
  assign out_ch.side_x = result.side_x;
  assign out_ch.side_y = result.side_y;
  assign out_ch.side_z = result.side_z;
  assign out_ch.eye_x  = result.eye_x;
  assign out_ch.eye_y  = result.eye_y;
  assign out_ch.eye_z  = result.eye_z;

endmodule

// File: bench/ecb_bench_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ecb_bench_pkg: result predictor and scoreboard for the camera basis unit
// Computes the expected forward, up, side and eye fields of one input
// transfer and compares results against the oldest expectation.
// ---------------------------------------------------------------------------
package ecb_bench_pkg;
  import ecb_pkg::*;

  typedef struct {
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
    pos_t        look_x;
    pos_t        look_y;
    pos_t        look_z;
    logic [23:0] view_dist;
  } angle_item_t;

  function automatic longint floor_div2(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Quarter-wave odd polynomial sine in Q14.
  function automatic longint poly_sine(logic [15:0] a);
    logic [1:0] q;
    longint t, x, x2, k, m, s;
    q = a[15:14];
    t = a[13:0];
    x = q[0] ? 16384 - t : t;
    x2 = (x * x) >> 14;
    k = 10512 - ((x2 * 1160) >> 14);
    m = 25736 - ((x2 * k) >> 14);
    s = (x * m) >> 14;
    return q[1] ? -s : s;
  endfunction

  function automatic ecb_result_t predict_basis(angle_item_t it);
    ecb_result_t r;
    longint sy, cy, sp, cp, sr, cr, f0, f1, f2, u0, u1, u2, d;
    sy = poly_sine(it.yaw);   cy = poly_sine(it.yaw + 16'd16384);
    sp = poly_sine(it.pitch); cp = poly_sine(it.pitch + 16'd16384);
    sr = poly_sine(it.roll);  cr = poly_sine(it.roll + 16'd16384);
    d = it.view_dist;
    f0 = floor_div2(sy * cp + 8192, 14);
    f1 = sp;
    f2 = floor_div2(cp * cy + 8192, 14);
    u0 = clip(floor_div2(-cy * sr * 16384 - sy * sp * cr + (64'sd1 << 27), 28), -32768, 32767);
    u1 = clip(floor_div2(cp * cr + 8192, 14), -32768, 32767);
    u2 = clip(floor_div2(-sy * sr * 16384 - sp * cr * cy + (64'sd1 << 27), 28), -32768, 32767);
    r.fwd_x = f0; r.fwd_y = f1; r.fwd_z = f2;
    r.up_x = u0;  r.up_y = u1;  r.up_z = u2;
    r.side_x = clip(floor_div2(f1 * u2 - f2 * u1 + 8192, 14), -32768, 32767);
    r.side_y = clip(floor_div2(f2 * u0 - f0 * u2 + 8192, 14), -32768, 32767);
    r.side_z = clip(floor_div2(f0 * u1 - f1 * u0 + 8192, 14), -32768, 32767);
    r.eye_x = clip(longint'(it.look_x) - floor_div2(f0 * d + 8192, 14),
                   -64'sd2147483648, 64'sd2147483647);
    r.eye_y = clip(longint'(it.look_y) - floor_div2(f1 * d + 8192, 14),
                   -64'sd2147483648, 64'sd2147483647);
    r.eye_z = clip(longint'(it.look_z) - floor_div2(f2 * d + 8192, 14),
                   -64'sd2147483648, 64'sd2147483647);
    return r;
  endfunction

  class basis_scoreboard;
    ecb_result_t pending_bases[$];
    int mismatches;
    int checked;

    function void note_input(angle_item_t it);
      pending_bases.push_back(predict_basis(it));
    endfunction

    function void check_result(ecb_result_t got);
      ecb_result_t want;
      if (pending_bases.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing expected: %p", got);
        return;
      end
      want = pending_bases.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d mismatch", checked);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass
endpackage

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for euler_to_camera_basis_unit
// Drives angle items with random gaps, stalls the result side, and checks
// every result field against a behavioral predictor of the unit.
// ---------------------------------------------------------------------------
module testbench;
  import ecb_pkg::*;
  import ecb_bench_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ecb_in_if  in_ch();
  ecb_out_if out_ch();

  euler_to_camera_basis_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  basis_scoreboard board = new();
  int  sent_count;
  bit  stimulus_done;
  // When set, the result side holds ready low for a long stretch.
  bit  hold_request;
  bit  hold_done;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.yaw_angle = '0; in_ch.pitch_angle = '0; in_ch.roll_angle = '0;
    in_ch.lookat_x = '0;  in_ch.lookat_y = '0;    in_ch.lookat_z = '0;
    in_ch.view_distance = '0;
    out_ch.ready = 1'b0;
  end

  // Gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and holds it until the unit takes the transfer.
  task automatic send_angles(angle_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.yaw_angle <= it.yaw;   in_ch.pitch_angle <= it.pitch;
    in_ch.roll_angle <= it.roll; in_ch.lookat_x <= it.look_x;
    in_ch.lookat_y <= it.look_y; in_ch.lookat_z <= it.look_z;
    in_ch.view_distance <= it.view_dist;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(it);
    sent_count++;
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic angle_item_t make_item(logic [15:0] y, logic [15:0] p, logic [15:0] r,
                                            pos_t lx, pos_t ly, pos_t lz, logic [23:0] d);
    angle_item_t it;
    it.yaw = y; it.pitch = p; it.roll = r;
    it.look_x = lx; it.look_y = ly; it.look_z = lz; it.view_dist = d;
    return it;
  endfunction

  // Angles near quadrant boundaries expose rounding and sign edges.
  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 3) == 0)
      return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 6) - 3);
    return 16'($urandom);
  endfunction

  function automatic pos_t rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF - 32'($urandom_range(0, 4096));
      1: return 32'sh80000000 + 32'($urandom_range(0, 4096));
      2: return 32'($urandom_range(0, 65535)) - 32'sd32768;
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_dist();
    case ($urandom_range(0, 3))
      0: return 24'hFFFFFF - 24'($urandom_range(0, 255));
      1: return 24'($urandom_range(0, 1024));
      default: return 24'($urandom);
    endcase
  endfunction

  // Stimulus process.
  initial begin
    angle_item_t it;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed part: cardinal angles, extreme angles, extreme positions and
    // distances so that eye saturates in both directions.
    send_angles(make_item(16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0));
    send_angles(make_item(16'h4000, 16'h0000, 16'h0000, 256, -256, 512, 24'h000100));
    send_angles(make_item(16'h8000, 16'h4000, 16'h0000, 0, 0, 0, 24'hFFFFFF));
    send_angles(make_item(16'hC000, 16'hC000, 16'h4000, 0, 0, 0, 24'hFFFFFF));
    send_angles(make_item(16'h7FFF, 16'h8000, 16'h8000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                          32'sh7FFFFFFF, 24'hFFFFFF));
    send_angles(make_item(16'h8000, 16'h7FFF, 16'hC000, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 24'hFFFFFF));
    send_angles(make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                          -1, 24'h000001));
    send_angles(make_item(16'h2000, 16'h2000, 16'h2000, 32'sh80000000, 32'sh80000000,
                          32'sh80000000, 24'hFFFFFF));
    send_angles(make_item(16'hE000, 16'h6000, 16'hA000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                          32'sh7FFFFFFF, 24'hFFFFFF));
    send_angles(make_item(16'h3FFF, 16'h4001, 16'hBFFF, 12345, -54321, 0, 24'h800000));
    send_angles(make_item(16'h5555, 16'hAAAA, 16'h0001, 0, 0, 0, 24'h7FFFFF));
    send_angles(make_item(16'h0001, 16'hC001, 16'h3FFF, -1, -1, -1, 24'hFFFFFF));
    idle_input(0);
    // Random part; around item 300 the sender waits for the pipe to drain,
    // around item 500 the receiver holds off while items keep coming.
    for (int n = 0; n < 1050; n++) begin
      if (n == 300) begin
        in_ch.valid <= 1'b0;
        wait (board.pending_bases.size() == 0);
        @(posedge clk);
      end
      if (n == 500) hold_request = 1'b1;
      if (n > 500 && !hold_done) idle_input(0);
      else idle_input(pick_gap());
      it = make_item(rand_angle(), rand_angle(), rand_angle(), rand_pos(), rand_pos(),
                     rand_pos(), rand_dist());
      send_angles(it);
    end
    in_ch.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Result side: random ready with one long hold-off counted here.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = ($urandom_range(0, 4) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result monitor samples at the edge, before nonblocking updates land.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      ecb_result_t got;
      got.fwd_x = out_ch.fwd_x;   got.fwd_y = out_ch.fwd_y;   got.fwd_z = out_ch.fwd_z;
      got.up_x = out_ch.up_x;     got.up_y = out_ch.up_y;     got.up_z = out_ch.up_z;
      got.side_x = out_ch.side_x; got.side_y = out_ch.side_y; got.side_z = out_ch.side_z;
      got.eye_x = out_ch.eye_x;   got.eye_y = out_ch.eye_y;   got.eye_z = out_ch.eye_z;
      board.check_result(got);
    end
  end

  // End of run: drain, let the pipeline settle, then report.
  initial begin
    wait (stimulus_done);
    wait (board.pending_bases.size() == 0);
    repeat (NUM_STAGES + 20) @(posedge clk);
    $display("Covered %0d transfers in, %0d results checked, %0d mismatches.",
             sent_count, board.checked, board.mismatches);
    $display("Included quadrant edges, saturated eye positions and a long output stall.");
    if (board.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #20000000;
    $display("Timeout waiting for results.");
    $display("Some tests failed");
    $finish;
  end
endmodule
